/* hw/rtl/gfau_pkg.sv */
package gfau_pkg;

  // field element width and exponent width
  localparam int unsigned FieldW = 8;
  localparam int unsigned ExpW = 16;

  // one chain cell per exponent bit
  localparam int unsigned NumCells = ExpW;

  // exponent that turns a^e into the inverse: 2^FieldW - 2
  localparam logic [ExpW-1:0] InvExp = ExpW'((1 << FieldW) - 2);

  // reset value of the reducing polynomial (x^8 + x^4 + x^3 + x^2 + 1)
  localparam logic [FieldW-1:0] PolyReset = FieldW'(29);

  // operation codes
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_MUL = 3'd1,
    OP_DIV = 3'd2,
    OP_POW = 3'd3,
    OP_INV = 3'd4
  } gfau_op_e;

  // payload carried from cell to cell
  typedef struct packed {
    logic              err;
    logic [FieldW-1:0] acc;
    logic [FieldW-1:0] base;
    logic [ExpW-1:0]   exp;
  } gfau_data_t;

  // shift-and-add carry-less product reduced by x^FieldW + poly
  function automatic logic [FieldW-1:0] gf_mul(input logic [FieldW-1:0] a,
                                               input logic [FieldW-1:0] b,
                                               input logic [FieldW-1:0] poly);
    logic [FieldW-1:0] acc;
    logic [FieldW-1:0] x;
    acc = '0;
    x = a;
    for (int i = 0; i < FieldW; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      x = {x[FieldW-2:0], 1'b0} ^ (x[FieldW-1] ? poly : '0);
    end
    return acc;
  endfunction

endpackage

/* hw/rtl/gfau_intf.sv */
// request channel
interface gfau_req_if;
  import gfau_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        req_type;
  logic [FieldW-1:0] operand_a;
  logic [FieldW-1:0] operand_b;
  logic [ExpW-1:0]   exponent;

  modport source (output valid, output req_type, output operand_a, output operand_b,
                  output exponent, input ready);
  modport sink (input valid, input req_type, input operand_a, input operand_b,
                input exponent, output ready);
endinterface

// response channel
interface gfau_rsp_if;
  import gfau_pkg::*;
  logic              valid;
  logic              ready;
  logic [FieldW-1:0] result;
  logic              div_by_zero;

  modport source (output valid, output result, output div_by_zero, input ready);
  modport sink (input valid, input result, input div_by_zero, output ready);
endinterface

/* hw/rtl/gfau_cell.sv */
module gfau_cell import gfau_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [FieldW-1:0] poly_i,
  input  logic              valid_i,
  input  gfau_data_t        data_i,
  output logic              valid_o,
  output gfau_data_t        data_o
);

  logic       valid_q;
  gfau_data_t data_d;
  gfau_data_t data_q;

  // one square-and-multiply step on the low exponent bit
  always_comb begin
    data_d.err  = data_i.err;
    data_d.acc  = data_i.exp[0] ? gf_mul(data_i.acc, data_i.base, poly_i) : data_i.acc;
    data_d.base = gf_mul(data_i.base, data_i.base, poly_i);
    data_d.exp  = data_i.exp >> 1;
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  // a request moving in is held by this cell on the next cycle
  a_cell_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && valid_i |=> valid_q)
    else $error("cell lost a request");

endmodule

/* hw/rtl/gf256_arithmetic_unit_top.sv */
// GF(2^8) arithmetic unit.
// Requests arrive on req (valid/ready) with req_type, operand_a, operand_b and
// exponent; one response per request leaves on rsp with result and
// div_by_zero, in request order. Operations: add (xor), multiply, divide,
// power and inverse. Every operation runs as square-and-multiply through a
// chain of 16 cells, one per exponent bit; multiply uses exponent 1, inverse
// and divide use exponent 254.
// Each cell registers a request in turn; rsp shows the last cell's output.
// Throughput: one request per cycle unless rsp stalls; each cell holds two
// 8x8 field multipliers. The reducing polynomial is written through cfg_we_i /
// cfg_wdata_i; the user writes it only while the unit is idle, which the unit
// does not enforce. Reset loads 0x1D and empties the chain.
// When rsp stalls, the whole chain holds and req.ready drops; it rises again
// in the cycle the last cell is taken or empty.
module gf256_arithmetic_unit_top import gfau_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  gfau_req_if.sink          req,
  gfau_rsp_if.source        rsp,
  input  logic              cfg_we_i,
  input  logic [FieldW-1:0] cfg_wdata_i
);

  logic [FieldW-1:0] poly_q;
  logic              en;
  gfau_data_t        prep;
  logic              valid_s [NumCells+1];
  gfau_data_t        data_s  [NumCells+1];

  // reducing polynomial register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= PolyReset;
    end else if (cfg_we_i) begin
      poly_q <= cfg_wdata_i;
    end
  end

  // chain advances unless the last cell holds an untaken response
  assign en        = !valid_s[NumCells] || rsp.ready;
  assign req.ready = en;

  // map each operation onto acc * base^exp
  always_comb begin
    prep.err  = 1'b0;
    prep.acc  = '0;
    prep.base = '0;
    prep.exp  = '0;
    case (req.req_type)
      OP_ADD: begin
        prep.acc = req.operand_a ^ req.operand_b;
      end
      OP_MUL: begin
        prep.acc  = req.operand_a;
        prep.base = req.operand_b;
        prep.exp  = ExpW'(1);
      end
      OP_DIV: begin
        prep.acc  = req.operand_a;
        prep.base = req.operand_b;
        prep.exp  = InvExp;
        prep.err  = (req.operand_b == '0);
      end
      OP_POW: begin
        prep.acc  = FieldW'(1);
        prep.base = req.operand_a;
        prep.exp  = req.exponent;
      end
      OP_INV: begin
        prep.acc  = FieldW'(1);
        prep.base = req.operand_a;
        prep.exp  = InvExp;
      end
      default: begin
        prep.acc = '0;
      end
    endcase
  end

  assign valid_s[0] = req.valid;
  assign data_s[0]  = prep;

  // chain of square-and-multiply cells
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    gfau_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .poly_i  (poly_q),
      .valid_i (valid_s[k]),
      .data_i  (data_s[k]),
      .valid_o (valid_s[k+1]),
      .data_o  (data_s[k+1])
    );
  end

  // response
  assign rsp.valid       = valid_s[NumCells];
  assign rsp.result      = data_s[NumCells].acc;
  assign rsp.div_by_zero = data_s[NumCells].err;

  // a zero divisor always leaves a zero result
  a_dbz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.div_by_zero |-> rsp.result == '0)
    else $error("division by zero with nonzero result");

  // an accepted request enters the first cell
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready |=> valid_s[1])
    else $error("accepted request not in first cell");

endmodule
